/* hdl/sxur_pkg.sv */
// ----------------------------------------------------------------------------
// sxur_pkg - shared types and constants of the seeded xorshift generator
// Holds the sequencer states, request codes, mixing constants and the
// xorshift step used by the generator and its multiplier unit.
// ----------------------------------------------------------------------------
package sxur_pkg;

   localparam int unsigned WORD_W = 32;

   // Request codes carried in req_type.
   localparam logic REQ_RESEED = 1'b0;
   localparam logic REQ_DRAW   = 1'b1;

   // Register index of the global seed (byte address bit 2).
   localparam logic CSR_IDX_SEED = 1'b0;

   localparam logic [WORD_W-1:0] GOLDEN_ADD   = 32'h9E37_79B9;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 32'h85EB_CA6B;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 32'hC2B2_AE35;
   localparam logic [WORD_W-1:0] STREAM_MUL   = 32'hA511_E9B3;
   localparam logic [WORD_W-1:0] NONZERO_FILL = 32'h6D2B_79F5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RS_MUL1,
      ST_RS_LOAD2,
      ST_RS_MUL2,
      ST_RS_LOAD3,
      ST_RS_MUL3,
      ST_RS_FIN,
      ST_DR_MUL,
      ST_DR_SUM,
      ST_DR_FIN
   } sxur_state_type;

   // Operand load request from the sequencer to the shared multiplier.
   typedef struct packed {
      logic              load;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } sxur_mul_ctl_type;

   // One xorshift 13/17/5 step.
   function automatic logic [WORD_W-1:0] sxur_advance(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] t1;
      logic [WORD_W-1:0] t2;
      t1 = v ^ (v << 13);
      t2 = t1 ^ (t1 >> 17);
      return t2 ^ (t2 << 5);
   endfunction

endpackage

/* hdl/sxur_req_if.sv */
// ----------------------------------------------------------------------------
// sxur_req_if - request channel of the seeded xorshift generator
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface sxur_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] stream_number;
   logic signed [31:0] range_low;
   logic signed [31:0] range_high;

   modport source (output valid, output req_type, output stream_number,
                   output range_low, output range_high, input ready);
   modport sink   (input valid, input req_type, input stream_number,
                   input range_low, input range_high, output ready);
endinterface

/* hdl/sxur_rsp_if.sv */
// ----------------------------------------------------------------------------
// sxur_rsp_if - result channel of the seeded xorshift generator
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface sxur_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_word;
   logic signed [31:0] scaled_value;

   modport source (output valid, output raw_word, output scaled_value, input ready);
   modport sink   (input valid, input raw_word, input scaled_value, output ready);
endinterface

/* hdl/sxur_mul.sv */
// ----------------------------------------------------------------------------
// sxur_mul - shared 32x32 multiplier of the seeded xorshift generator
// Registers a pair of operands on request and registers their full product
// in the following cycle.
// ----------------------------------------------------------------------------
module sxur_mul import sxur_pkg::*; (
   input  logic                  clock,
   input  sxur_mul_ctl_type      ctl,
   output logic [2*WORD_W-1:0]   product
);

   logic [WORD_W-1:0]   a_ff;
   logic [WORD_W-1:0]   b_ff;
   logic [2*WORD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         a_ff <= ctl.a;
         b_ff <= ctl.b;
      end
      prod_ff <= {{WORD_W{1'b0}}, a_ff} * {{WORD_W{1'b0}}, b_ff};
   end

   assign product = prod_ff;

endmodule

/* hdl/seeded_xorshift_uniform_rng.sv */
// A draw word runs through ST_DR_MUL, ST_DR_SUM and ST_DR_FIN before its result is
// registered; ST_DR_FIN waits while the output register holds an unread result.
// A reseed word keeps the block busy for three multiplies and gives no result.
// The single shared multiplier serves both; no new word is taken until idle.
// Reset (synchronous, active high) loads the generator with 0x6D2B79F5, clears
// the global seed and drops any pending result.
// ----------------------------------------------------------------------------
// seeded_xorshift_uniform_rng - seeded xorshift32 uniform generator
// Keeps one xorshift32 state, reseeds it from a splitmix32 mix of the global
// seed and a stream number, and returns raw and range-scaled draws.
// ----------------------------------------------------------------------------
module seeded_xorshift_uniform_rng import sxur_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sxur_req_if.sink    req,
   sxur_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Sequencer state and its next value.
   sxur_state_type state_ff;
   sxur_state_type state_in;

   // Generator state, configured seed, and per-word working registers.
   logic [WORD_W-1:0]   gen_ff,  gen_in;
   logic [WORD_W-1:0]   seed_ff;
   logic [WORD_W-1:0]   lo_ff,   lo_in;
   logic                neg_ff,  neg_in;
   logic [WORD_W-1:0]   mag_ff,  mag_in;
   logic [2*WORD_W:0]   sum_ff,  sum_in;

   // Output register that decouples the result channel from the sequencer.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   raw_ff,    raw_in;
   logic [WORD_W-1:0]   scaled_ff, scaled_in;

   sxur_mul_ctl_type    mul_ctl;
   logic [2*WORD_W-1:0] product;

   logic [WORD_W-1:0]   adv_word;
   logic [WORD_W-1:0]   diff_hl;
   logic [WORD_W-1:0]   diff_lh;
   logic                req_neg;
   logic [WORD_W-1:0]   mix_add;
   logic [WORD_W-1:0]   mix_mid;
   logic [WORD_W-1:0]   mix_out;
   logic [WORD_W-1:0]   quot;
   logic                inexact;
   logic [WORD_W-1:0]   scaled_word;
   logic                accept;
   logic                out_free;
   logic                csr_write;

   sxur_mul u_mul (
      .clock   (clock),
      .ctl     (mul_ctl),
      .product (product)
   );

   // The configuration port never stalls. Only bit 2 of the address selects a
   // register, so the low byte-lane bits are ignored.
   assign pready    = 1'b1;
   assign prdata    = seed_ff;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_IDX_SEED);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_write) begin
         seed_ff <= pwdata;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // Draw front end: next xorshift word, and the magnitude and sign of the
   // interval width. The width is exact in 33 bits; its magnitude fits in 32.
   assign adv_word = sxur_advance(gen_ff);
   assign diff_hl  = req.range_high - req.range_low;
   assign diff_lh  = req.range_low - req.range_high;
   assign req_neg  = (req.range_high < req.range_low);

   // Splitmix32 stages between the shared multiplies.
   assign mix_add = (seed_ff ^ product[WORD_W-1:0]) + GOLDEN_ADD;
   assign mix_mid = product[WORD_W-1:0];
   assign mix_out = product[WORD_W-1:0] ^ (product[WORD_W-1:0] >> 16);

   // The fraction is (2r+1)/2^33, so the scaled magnitude is
   // floor((2*mag*r + mag) / 2^33). For a negative width the offset is the
   // floor of a negative value: low - q - 1 when any fraction bit is set,
   // which is low + ~q + 1 - inexact.
   assign quot        = sum_ff[2*WORD_W:WORD_W+1];
   assign inexact     = |sum_ff[WORD_W:0];
   assign scaled_word = neg_ff ? (lo_ff + ~quot + {{(WORD_W-1){1'b0}}, ~inexact})
                               : (lo_ff + quot);

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      lo_in        = lo_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      raw_in       = raw_ff;
      scaled_in    = scaled_ff;
      mul_ctl      = '{load: 1'b0, a: '0, b: '0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.req_type == REQ_DRAW) begin
                  gen_in   = adv_word;
                  lo_in    = req.range_low;
                  neg_in   = req_neg;
                  mag_in   = req_neg ? diff_lh : diff_hl;
                  mul_ctl  = '{load: 1'b1, a: (req_neg ? diff_lh : diff_hl), b: adv_word};
                  state_in = ST_DR_MUL;
               end else begin
                  mul_ctl  = '{load: 1'b1, a: req.stream_number, b: STREAM_MUL};
                  state_in = ST_RS_MUL1;
               end
            end
         end
         ST_RS_MUL1: begin
            state_in = ST_RS_LOAD2;
         end
         ST_RS_LOAD2: begin
            mul_ctl  = '{load: 1'b1, a: (mix_add ^ (mix_add >> 16)), b: MIX_MUL_A};
            state_in = ST_RS_MUL2;
         end
         ST_RS_MUL2: begin
            state_in = ST_RS_LOAD3;
         end
         ST_RS_LOAD3: begin
            mul_ctl  = '{load: 1'b1, a: (mix_mid ^ (mix_mid >> 13)), b: MIX_MUL_B};
            state_in = ST_RS_MUL3;
         end
         ST_RS_MUL3: begin
            state_in = ST_RS_FIN;
         end
         ST_RS_FIN: begin
            // The state must never be zero, or xorshift would stick there.
            gen_in   = (mix_out == '0) ? NONZERO_FILL : mix_out;
            state_in = ST_IDLE;
         end
         ST_DR_MUL: begin
            state_in = ST_DR_SUM;
         end
         ST_DR_SUM: begin
            sum_in   = {product, 1'b0} + {{(WORD_W+1){1'b0}}, mag_ff};
            state_in = ST_DR_FIN;
         end
         ST_DR_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               raw_in       = gen_ff;
               scaled_in    = scaled_word;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= NONZERO_FILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      sum_ff    <= sum_in;
      raw_ff    <= raw_in;
      scaled_ff <= scaled_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.raw_word     = raw_ff;
   assign rsp.scaled_value = scaled_ff;

endmodule

/* hdl/sxur_checker.sv */
// ----------------------------------------------------------------------------
// sxur_checker - port-level checks of the seeded xorshift generator
// Watches the request and result channels for timing and value rules.
// ----------------------------------------------------------------------------
module sxur_checker import sxur_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] raw_word,
   input logic [31:0] scaled_value
);

   // No result is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The block works on one word at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A draw into an empty output shows its result after ST_DR_MUL, ST_DR_SUM and ST_DR_FIN.
   a_draw_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_DRAW) && !rsp_valid |-> ##4 rsp_valid)
      else $error("draw result missing");

   // The generator state is never zero, so neither is a raw word.
   a_raw_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (raw_word != '0))
      else $error("zero raw word");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(raw_word) && $stable(scaled_value))
      else $error("result changed while stalled");

endmodule

bind seeded_xorshift_uniform_rng sxur_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_type     (req.req_type),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .raw_word     (rsp.raw_word),
   .scaled_value (rsp.scaled_value)
);
